[design/yuv444_dual_yuv420_packer_defines.svh]
// Assertion macros for the yuv444_dual_yuv420_packer checker.
// Needs clk and rst in the scope where the macros are used.
`ifndef YUV444_DUAL_YUV420_PACKER_DEFINES_SVH
`define YUV444_DUAL_YUV420_PACKER_DEFINES_SVH

// Check a property on every clock edge outside reset
`define YUVPK_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error(msg);

// Check a property on every clock edge, reset included
`define YUVPK_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) \
    else $error(msg);

`endif

[design/yuvpk_pkg.sv]
// Shared types and constants for the dual 4:2:0 packer.
// No dependencies.
package yuvpk_pkg;

  localparam int unsigned LaneCount = 4;

  // Lane order inside a quad
  localparam int unsigned LaneTopLeft     = 0;
  localparam int unsigned LaneTopRight    = 1;
  localparam int unsigned LaneBottomLeft  = 2;
  localparam int unsigned LaneBottomRight = 3;

  typedef struct packed {
    logic [23:0] pixel_top_left;
    logic [23:0] pixel_top_right;
    logic [23:0] pixel_bottom_left;
    logic [23:0] pixel_bottom_right;
    logic [10:0] block_column;
    logic [10:0] block_row;
  } in_item_t;

  typedef struct packed {
    logic [31:0] main_luma_quad;
    logic [7:0]  main_u;
    logic [7:0]  main_v;
    logic [15:0] aux_luma_u_pair;
    logic [15:0] aux_luma_v_pair;
    logic [11:0] aux_luma_u_row;
    logic [11:0] aux_luma_v_row;
    logic [7:0]  aux_u;
    logic [7:0]  aux_v;
    logic [10:0] out_block_column;
    logic [10:0] out_block_row;
  } out_item_t;

  // One converted pixel
  typedef struct packed {
    logic [7:0] y;
    logic [7:0] u;
    logic [7:0] v;
  } ycc_t;

  // Control and position that travel beside the lane results
  typedef struct packed {
    logic        valid;
    logic [10:0] column;
    logic [10:0] row;
  } tag_t;

endpackage

[design/yuvpk_lane.sv]
// One pixel lane: BT.601 studio-swing BGR to Y, U, V with a result register.
// Depends on yuvpk_pkg.
module yuvpk_lane (
  input  logic              clk,
  input  logic [23:0]       pixel,
  output yuvpk_pkg::ycc_t   ycc
);
  import yuvpk_pkg::*;

  logic [7:0]         blue;
  logic [7:0]         green;
  logic [7:0]         red;
  logic [16:0]        y_sum;
  logic [8:0]         y_pre;
  logic signed [17:0] u_sum;
  logic signed [17:0] v_sum;
  ycc_t               ycc_next;

  // Clamp a shifted signed sum to a byte
  function automatic logic [7:0] clamp_u8(input logic signed [9:0] x);
    logic [7:0] r;
    if (x < 0) begin
      r = 8'd0;
    end else if (x > 10'sd255) begin
      r = 8'hFF;
    end else begin
      r = x[7:0];
    end
    return r;
  endfunction

  assign blue  = pixel[7:0];
  assign green = pixel[15:8];
  assign red   = pixel[23:16];

  // Luma: sum is never negative, so the shift is a plain byte select
  assign y_sum = 17'd66 * {9'd0, red} + 17'd129 * {9'd0, green}
               + 17'd25 * {9'd0, blue} + 17'd128;
  assign y_pre = {1'b0, y_sum[15:8]} + 9'd16;

  // Chroma: fold the +128 offset and a rounding 128 in as 128*256 + 128 before the floor shift
  assign u_sum = 18'sd32896 + 18'sd112 * $signed({10'd0, blue})
               - 18'sd38 * $signed({10'd0, red}) - 18'sd74 * $signed({10'd0, green});
  assign v_sum = 18'sd32896 + 18'sd112 * $signed({10'd0, red})
               - 18'sd94 * $signed({10'd0, green}) - 18'sd18 * $signed({10'd0, blue});

  always_comb begin
    ycc_next.y = y_pre[8] ? 8'hFF : y_pre[7:0];
    ycc_next.u = clamp_u8(u_sum[17:8]);
    ycc_next.v = clamp_u8(v_sum[17:8]);
  end

  // Hold the converted pixel for the merge stage
  always_ff @(posedge clk) begin
    ycc <= ycc_next;
  end

endmodule

[design/yuvpk_merge.sv]
// Merge stage: averages main chroma, packs both views, registers the result.
// Depends on yuvpk_pkg.
module yuvpk_merge (
  input  logic                 clk,
  input  logic                 rst,
  input  yuvpk_pkg::ycc_t      lane [yuvpk_pkg::LaneCount],
  input  yuvpk_pkg::tag_t      tag,
  output logic                 done,
  output yuvpk_pkg::out_item_t result
);
  import yuvpk_pkg::*;

  logic [9:0] u_total;
  logic [9:0] v_total;
  out_item_t  result_next;

  // Sum the four chroma samples of the quad
  assign u_total = {2'd0, lane[LaneTopLeft].u} + {2'd0, lane[LaneTopRight].u}
                 + {2'd0, lane[LaneBottomLeft].u} + {2'd0, lane[LaneBottomRight].u};
  assign v_total = {2'd0, lane[LaneTopLeft].v} + {2'd0, lane[LaneTopRight].v}
                 + {2'd0, lane[LaneBottomLeft].v} + {2'd0, lane[LaneBottomRight].v};

  // Pack main and auxiliary views; aux rows interleave in 8-row blocks
  always_comb begin
    result_next.main_luma_quad   = {lane[LaneBottomRight].y, lane[LaneBottomLeft].y,
                                    lane[LaneTopRight].y, lane[LaneTopLeft].y};
    result_next.main_u           = u_total[9:2];
    result_next.main_v           = v_total[9:2];
    result_next.aux_luma_u_pair  = {lane[LaneBottomRight].u, lane[LaneBottomLeft].u};
    result_next.aux_luma_v_pair  = {lane[LaneBottomRight].v, lane[LaneBottomLeft].v};
    result_next.aux_luma_u_row   = {tag.row[10:3], 1'b0, tag.row[2:0]};
    result_next.aux_luma_v_row   = {tag.row[10:3], 1'b1, tag.row[2:0]};
    result_next.aux_u            = lane[LaneTopRight].u;
    result_next.aux_v            = lane[LaneTopRight].v;
    result_next.out_block_column = tag.column;
    result_next.out_block_row    = tag.row;
  end

  // Register the strobe and the result
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= tag.valid;
    end
    result <= result_next;
  end

endmodule

[design/yuv444_dual_yuv420_packer.sv]
// Top level of the BT.601 quad converter and dual 4:2:0 view packer.
// Depends on yuvpk_pkg, yuvpk_lane and yuvpk_merge.
//
// Usage:
//   Input: drive item with one 2x2 BGR quad and its block position and raise
//   start. The quad transfers at each rising edge where start is high and
//   busy is low. busy is high only while rst is high, so outside reset a
//   quad can transfer on every clock.
//   Output: done is high for exactly one cycle per quad, with the packed
//   main and auxiliary view samples on result. The result transfers at the
//   edge that ends that cycle; the receiver cannot stall the block and
//   must take every result as it appears.
//   Path: each quad is registered in the four pixel lanes, then in the merge
//   stage, before its result transfers.
//   Throughput: one quad per clock outside reset, set by the four converter lanes
//   that each finish one pixel per cycle.
//   Reset: synchronous, active high; clears the valid bits in both stages,
//   so no result appears after reset until a new quad transfers. Results
//   are delivered in transfer order.
module yuv444_dual_yuv420_packer (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  output logic                 busy,
  input  yuvpk_pkg::in_item_t  item,
  output logic                 done,
  output yuvpk_pkg::out_item_t result
);
  import yuvpk_pkg::*;

  logic [23:0] pixel [LaneCount];
  ycc_t        lane_ycc [LaneCount];
  tag_t        tag;

  assign busy = rst;

  assign pixel[LaneTopLeft]     = item.pixel_top_left;
  assign pixel[LaneTopRight]    = item.pixel_top_right;
  assign pixel[LaneBottomLeft]  = item.pixel_bottom_left;
  assign pixel[LaneBottomRight] = item.pixel_bottom_right;

  // Convert the four pixels side by side
  for (genvar i = 0; i < LaneCount; i++) begin : g_lane
    yuvpk_lane u_lane (
      .clk   (clk),
      .pixel (pixel[i]),
      .ycc   (lane_ycc[i])
    );
  end

  // Carry the transfer flag and block position beside the lanes
  always_ff @(posedge clk) begin
    if (rst) begin
      tag.valid <= 1'b0;
    end else begin
      tag.valid <= start && !busy;
    end
    tag.column <= item.block_column;
    tag.row    <= item.block_row;
  end

  // Combine the lanes into the output views
  yuvpk_merge u_merge (
    .clk    (clk),
    .rst    (rst),
    .lane   (lane_ycc),
    .tag    (tag),
    .done   (done),
    .result (result)
  );

endmodule

[design/yuvpk_checker.sv]
// Port-level checker for yuv444_dual_yuv420_packer, bound to the top level.
// Depends on yuvpk_pkg and yuv444_dual_yuv420_packer_defines.svh.
`include "yuv444_dual_yuv420_packer_defines.svh"

module yuvpk_checker (
  input logic                 clk,
  input logic                 rst,
  input logic                 start,
  input logic                 busy,
  input yuvpk_pkg::in_item_t  item,
  input logic                 done,
  input yuvpk_pkg::out_item_t result
);
  import yuvpk_pkg::*;

  // Every transfer yields exactly one result, after the lane and merge registers
  `YUVPK_ASSERT(a_latency, (!$past(rst) && !$past(rst, 2)) |-> (done == $past(start && !busy, 2)), "result strobe does not match a transfer two cycles earlier")

  // The echoed position belongs to the quad that caused the result
  `YUVPK_ASSERT(a_position, (done && !$past(rst) && !$past(rst, 2)) |-> (result.out_block_column == $past(item.block_column, 2) && result.out_block_row == $past(item.block_row, 2)), "result position does not match its quad")

  // The V aux-luma row sits eight rows below the U row
  `YUVPK_ASSERT(a_aux_rows, done |-> (result.aux_luma_v_row == result.aux_luma_u_row + 12'd8), "aux luma rows are not eight apart")

  // No result in the cycle after reset
  `YUVPK_ASSERT_ALWAYS(a_reset_quiet, $past(rst) |-> !done, "result strobe right after reset")

endmodule

bind yuv444_dual_yuv420_packer yuvpk_checker u_yuvpk_checker (.*);
